>>> rtl/baro_temp_pressure_compensation_macros.svh
// assertion macros for the barometric compensation block
// used by the top level; expects clk and rst_n in the including scope
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define BCMP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BCMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BCMP_ASSERT_NOW(lbl, ante, cons, msg)
`define BCMP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/bcmp_pkg.sv
// types and constants shared by the barometric compensation pipeline
// no dependencies
`default_nettype none

package bcmp_pkg;

    localparam int TCAL_W   = 48;
    localparam int PCAL_W   = 64;
    localparam int P9_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TEMP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PLOW  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PHIGH = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST  = 8'd3;

    // fine temperature and pressure datapath widths
    localparam int FINE_W = 26;
    localparam int V1_W   = FINE_W + 1;
    localparam int X_W    = 58;
    localparam int NUM_W  = 64;
    localparam int DEN_W  = 32;

    // divider: quotient bits per stage and stage count
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = NUM_W / DIV_STEP;

    localparam int FINE_OFFSET = 128000;
    localparam int PRESS_FULL  = 1048576;
    localparam int PRESS_SCALE = 3125;
    localparam int TEMP_ROUND  = 128;
    localparam int TEMP_MAX    = 8388607;
    localparam int TEMP_MIN    = -8388608;
    localparam logic signed [63:0] X_BIAS = 64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
    } out_item_t;

    // sideband carried alongside the pressure math
    typedef struct packed {
        logic [19:0]        raw_pressure;
        logic signed [23:0] temperature_centi;
    } side_t;

    // operands of the unsigned divider
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             zero;
        side_t            side;
    } div_item_t;

    typedef struct packed {
        logic [NUM_W-1:0] quo;
        logic             neg;
        logic             zero;
        side_t            side;
    } quo_item_t;

endpackage

`default_nettype wire

>>> rtl/bcmp_temp.sv
// temperature stages: fine temperature and centi-degree result
// depends on bcmp_pkg
`default_nettype none

module bcmp_temp
    import bcmp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_vld,
    input  in_item_t                 in_item,
    input  logic [TCAL_W-1:0]        tcal,
    output logic                     out_vld,
    output logic signed [FINE_W-1:0] out_fine,
    output side_t                    out_side
);

    localparam int NST = 5;

    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;

    logic [NST-1:0] vld_reg;
    side_t          side_reg [NST];

    logic signed [17:0] ta_reg, ta_next;
    logic signed [16:0] td_reg, td_next;
    logic signed [33:0] ma_reg, ma_next;
    logic [31:0]        dd_reg, dd_next;
    logic signed [33:0] dd_full;
    logic signed [22:0] a_reg, a_next;
    logic signed [36:0] mb_reg, mb_next;
    logic signed [FINE_W-1:0] fine_reg, fine_next;
    logic signed [FINE_W-1:0] fine5_reg;
    logic signed [FINE_W+2:0] tx, tq;
    logic signed [23:0]       tc_next;

    assign t1 = tcal[15:0];
    assign t2 = $signed(tcal[31:16]);
    assign t3 = $signed(tcal[47:32]);

    // stage 1: raw differences
    assign ta_next = $signed({1'b0, in_item.raw_temperature[19:3]})
                   - $signed({1'b0, t1, 1'b0});
    assign td_next = $signed({1'b0, in_item.raw_temperature[19:4]}) - $signed({1'b0, t1});

    // stage 2: products
    assign ma_next = ta_reg * t2;
    assign dd_full = td_reg * td_reg;
    assign dd_next = dd_full[31:0];

    // stage 3: scale and second product
    assign a_next  = ma_reg[33:11];
    assign mb_next = $signed({1'b0, dd_reg[31:12]}) * t3;

    // stage 4: fine temperature
    assign fine_next = FINE_W'(a_reg) + FINE_W'($signed(mb_reg[36:14]));

    // stage 5: centi-degrees with rounding and saturation
    always_comb
    begin
        tx = ((FINE_W+3)'(fine_reg) <<< 2) + (FINE_W+3)'(fine_reg)
           + (FINE_W+3)'(TEMP_ROUND);
        tq = tx >>> 8;
        if (tq > TEMP_MAX)
            tc_next = 24'(TEMP_MAX);
        else if (tq < TEMP_MIN)
            tc_next = 24'(TEMP_MIN);
        else
            tc_next = 24'(tq);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[NST-2:0], in_vld};
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ta_reg   <= ta_next;
            td_reg   <= td_next;
            ma_reg   <= ma_next;
            dd_reg   <= dd_next;
            a_reg    <= a_next;
            mb_reg   <= mb_next;
            fine_reg <= fine_next;
            fine5_reg <= fine_reg;
            side_reg[0].raw_pressure      <= in_item.raw_pressure;
            side_reg[0].temperature_centi <= '0;
            for (int k = 1; k < NST - 1; k++)
                side_reg[k] <= side_reg[k-1];
            side_reg[NST-1].raw_pressure      <= side_reg[NST-2].raw_pressure;
            side_reg[NST-1].temperature_centi <= tc_next;
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_fine = fine5_reg;
    assign out_side = side_reg[NST-1];

endmodule

`default_nettype wire

>>> rtl/bcmp_pcoef.sv
// pressure stages before the divide: dividend and divisor magnitudes
// depends on bcmp_pkg
`default_nettype none

module bcmp_pcoef
    import bcmp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_vld,
    input  logic signed [FINE_W-1:0] in_fine,
    input  side_t                    in_side,
    input  logic [PCAL_W-1:0]        pcal_low,
    input  logic [PCAL_W-1:0]        pcal_high,
    output logic                     out_vld,
    output div_item_t                out_item
);

    localparam int NST = 7;

    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6;

    logic [NST-1:0] vld_reg;
    side_t          side_reg [NST];

    logic signed [V1_W-1:0]    v1_reg, v1_next;
    logic signed [2*V1_W-1:0]  sq_reg, sq_next;
    logic signed [V1_W+15:0]   m5_reg, m5_next, m2_reg, m2_next;
    logic signed [V1_W+15:0]   m5c_reg, m2c_reg;
    logic signed [63:0]        m6_reg, m6_next, m3_reg, m3_next;
    logic signed [63:0]        m3s, m2s;
    logic signed [63:0]        v2_reg, v2_next, xsum;
    logic signed [X_W-1:0]     x_reg;
    logic [20:0]               np_reg, np_next;
    logic [63:0]               d_reg, d_next;
    logic signed [X_W+16:0]    mx_full;
    logic signed [30:0]        dv_reg;
    logic [63:0]               num_reg, num_next;
    logic [DEN_W-1:0]          den_next, den_reg;
    logic                      dneg_reg, zero_reg;
    div_item_t                 out_reg, out_next;

    assign p1 = pcal_low[15:0];
    assign p2 = $signed(pcal_low[31:16]);
    assign p3 = $signed(pcal_low[47:32]);
    assign p4 = $signed(pcal_low[63:48]);
    assign p5 = $signed(pcal_high[15:0]);
    assign p6 = $signed(pcal_high[31:16]);

    // stage 1: offset fine temperature
    assign v1_next = V1_W'(in_fine) - V1_W'(FINE_OFFSET);

    // stage 2: square and linear terms
    assign sq_next = v1_reg * v1_reg;
    assign m5_next = v1_reg * p5;
    assign m2_next = v1_reg * p2;

    // stage 3: quadratic terms, wrapped to 64 bits
    assign m6_next = 64'(sq_reg) * 64'(p6);
    assign m3_next = 64'(sq_reg) * 64'(p3);

    // stage 4: sum the two polynomials, inverted raw pressure
    assign m3s     = m3_reg >>> 8;
    assign m2s     = 64'(m2c_reg) <<< 12;
    assign xsum    = m3s + m2s + X_BIAS;
    assign v2_next = m6_reg + (64'(m5c_reg) <<< 17) + (64'(p4) <<< 35);
    assign np_next = 21'(PRESS_FULL) - {1'b0, side_reg[2].raw_pressure};

    // stage 5: dividend base and divisor
    assign d_next  = {12'd0, np_reg, 31'd0} - v2_reg;
    assign mx_full = x_reg * $signed({1'b0, p1});

    // stage 6: scale dividend, divisor magnitude
    assign num_next = d_reg * 64'(PRESS_SCALE);
    assign den_next = dv_reg[30] ? (DEN_W'(0) - DEN_W'(dv_reg)) : DEN_W'(dv_reg);

    // stage 7: dividend magnitude and quotient sign
    always_comb
    begin
        out_next.num  = num_reg[63] ? (64'd0 - num_reg) : num_reg;
        out_next.den  = den_reg;
        out_next.neg  = num_reg[63] ^ dneg_reg;
        out_next.zero = zero_reg;
        out_next.side = side_reg[NST-2];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[NST-2:0], in_vld};
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            v1_reg   <= v1_next;
            sq_reg   <= sq_next;
            m5_reg   <= m5_next;
            m2_reg   <= m2_next;
            m6_reg   <= m6_next;
            m3_reg   <= m3_next;
            m5c_reg  <= m5_reg;
            m2c_reg  <= m2_reg;
            v2_reg   <= v2_next;
            x_reg    <= X_W'(xsum);
            np_reg   <= np_next;
            d_reg    <= d_next;
            dv_reg   <= $signed(mx_full[63:33]);
            num_reg  <= num_next;
            den_reg  <= den_next;
            dneg_reg <= dv_reg[30];
            zero_reg <= (dv_reg == '0);
            out_reg  <= out_next;
            side_reg[0] <= in_side;
            for (int k = 1; k < NST; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_item = out_reg;

endmodule

`default_nettype wire

>>> rtl/bcmp_div.sv
// pipelined restoring divider, a few quotient bits per stage
// depends on bcmp_pkg
`default_nettype none

module bcmp_div
    import bcmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      in_vld,
    input  div_item_t in_item,
    output logic      out_vld,
    output quo_item_t out_item
);

    logic             vld_reg [DIV_STAGES];
    div_item_t        it_reg  [DIV_STAGES];
    logic [DEN_W-1:0] rem_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic             v_in;
        div_item_t        it_in;
        logic [DEN_W-1:0] r_in;
        logic [NUM_W-1:0] w_out;
        logic [DEN_W-1:0] r_out;
        div_item_t        it_out;

        if (k == 0)
        begin : g_first
            assign v_in  = in_vld;
            assign it_in = in_item;
            assign r_in  = '0;
        end
        else
        begin : g_next
            assign v_in  = vld_reg[k-1];
            assign it_in = it_reg[k-1];
            assign r_in  = rem_reg[k-1];
        end

        // shift in dividend bits, subtract where the divisor fits
        always_comb
        begin
            logic [DEN_W:0] rs;
            w_out = it_in.num;
            r_out = r_in;
            for (int j = 0; j < DIV_STEP; j++)
            begin
                rs    = {r_out, w_out[NUM_W-1]};
                w_out = {w_out[NUM_W-2:0], 1'b0};
                if (rs >= {1'b0, it_in.den})
                begin
                    r_out    = DEN_W'(rs - {1'b0, it_in.den});
                    w_out[0] = 1'b1;
                end
                else
                    r_out = rs[DEN_W-1:0];
            end
            it_out     = it_in;
            it_out.num = w_out;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (advance)
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                it_reg[k]  <= it_out;
                rem_reg[k] <= r_out;
            end
        end
    end

    assign out_vld       = vld_reg[DIV_STAGES-1];
    assign out_item.quo  = it_reg[DIV_STAGES-1].num;
    assign out_item.neg  = it_reg[DIV_STAGES-1].neg;
    assign out_item.zero = it_reg[DIV_STAGES-1].zero;
    assign out_item.side = it_reg[DIV_STAGES-1].side;

endmodule

`default_nettype wire

>>> rtl/bcmp_pfin.sv
// pressure stages after the divide: second-order correction and offset
// depends on bcmp_pkg
`default_nettype none

module bcmp_pfin
    import bcmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_vld,
    input  quo_item_t         in_item,
    input  logic [PCAL_W-1:0] pcal_high,
    input  logic [P9_W-1:0]   pcal_last,
    output logic              out_vld,
    output out_item_t         out_item
);

    localparam int NST = 6;

    logic signed [15:0] p7, p8, p9;

    logic [NST-1:0]     vld_reg;
    logic signed [23:0] temp_reg [NST-1];
    logic               zero_reg [NST-1];

    logic signed [63:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [63:0] ps;
    logic [63:0]        ll_reg, ll_next;
    logic [31:0]        lh_reg, lh_next;
    logic signed [63:0] w2m_reg, w2m_next;
    logic signed [63:0] s_reg;
    logic signed [63:0] w2c_reg, w2d_reg;
    logic signed [63:0] m9_reg, m9_next, m9s;
    logic signed [63:0] t_reg, t_next, res;
    out_item_t          out_reg, out_next;

    assign p7 = $signed(pcal_high[47:32]);
    assign p8 = $signed(pcal_high[63:48]);
    assign p9 = $signed(pcal_last);

    // stage 2: square of the scaled pressure, split in 32-bit halves
    assign ps       = pa_reg >>> 13;
    assign ll_next  = 64'(ps[31:0]) * 64'(ps[31:0]);
    assign lh_next  = ps[31:0] * ps[63:32];
    assign w2m_next = pa_reg * 64'(p8);

    // stage 4: times the second-order coefficient
    assign m9_next = s_reg * 64'(p9);

    // stage 5: add corrections
    assign m9s    = m9_reg >>> 25;
    assign t_next = pd_reg + m9s + w2d_reg;

    // stage 6: final scale and offset
    always_comb
    begin
        res = (t_reg >>> 8) + (64'(p7) <<< 4);
        out_next.temperature_centi = temp_reg[NST-2];
        out_next.pressure_invalid  = zero_reg[NST-2];
        out_next.pressure_q24_8    = zero_reg[NST-2] ? 32'd0 : res[31:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[NST-2:0], in_vld};
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pa_reg  <= in_item.neg ? $signed(64'd0 - in_item.quo) : $signed(in_item.quo);
            pb_reg  <= pa_reg;
            ll_reg  <= ll_next;
            lh_reg  <= lh_next;
            w2m_reg <= w2m_next;
            pc_reg  <= pb_reg;
            s_reg   <= $signed(ll_reg + {lh_reg[30:0], 33'd0});
            w2c_reg <= w2m_reg >>> 19;
            pd_reg  <= pc_reg;
            m9_reg  <= m9_next;
            w2d_reg <= w2c_reg;
            t_reg   <= t_next;
            out_reg <= out_next;
            temp_reg[0] <= in_item.side.temperature_centi;
            zero_reg[0] <= in_item.zero;
            for (int k = 1; k < NST - 1; k++)
            begin
                temp_reg[k] <= temp_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_item = out_reg;

endmodule

`default_nettype wire

>>> rtl/baro_temp_pressure_compensation.sv
// Barometric temperature/pressure compensation, integer formulas.
// Input channel in_valid/in_stall carries one raw temperature and one raw
// pressure reading; output channel out_valid/out_stall carries temperature in
// 0.01 degC (saturated to 24 bits), pressure in Q24.8 Pa and an invalid flag
// that is set, with pressure 0, when the pressure divisor is zero.
// Calibration words come in through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high, writes to unknown indexes are dropped, and
// writes are expected only while no transaction is in flight.
// Throughput: one transaction per cycle unless out_stall holds the pipeline.
// The path runs through the pipelined 64-bit divider (16 stages,
// 4 quotient bits each) plus 18 stages of multiply/add around it.
// A stalled output holds the whole pipeline; in_stall then rises in the
// same cycle, and nothing is lost or repeated.
// Reset clears all valid bits and the calibration registers to zero.
// depends on bcmp_pkg, bcmp_temp, bcmp_pcoef, bcmp_div, bcmp_pfin
`default_nettype none
`include "baro_temp_pressure_compensation_macros.svh"

module baro_temp_pressure_compensation
    import bcmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TCAL_W-1:0] tcal_reg;
    logic [PCAL_W-1:0] pcal_low_reg;
    logic [PCAL_W-1:0] pcal_high_reg;
    logic [P9_W-1:0]   pcal_last_reg;

    logic                     advance;
    logic                     t_vld;
    logic signed [FINE_W-1:0] t_fine;
    side_t                    t_side;
    logic                     c_vld;
    div_item_t                c_item;
    logic                     d_vld;
    quo_item_t                d_item;

    // pipeline moves when the output register is free or being taken
    assign advance   = !out_valid || !out_stall;
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    // calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg      <= '0;
            pcal_low_reg  <= '0;
            pcal_high_reg <= '0;
            pcal_last_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDX_TEMP:  tcal_reg      <= cfg_data[TCAL_W-1:0];
                CFG_IDX_PLOW:  pcal_low_reg  <= cfg_data;
                CFG_IDX_PHIGH: pcal_high_reg <= cfg_data;
                CFG_IDX_LAST:  pcal_last_reg <= cfg_data[P9_W-1:0];
                default:       ;
            endcase
        end
    end

    bcmp_temp u_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (in_valid),
        .in_item  (in_data),
        .tcal     (tcal_reg),
        .out_vld  (t_vld),
        .out_fine (t_fine),
        .out_side (t_side)
    );

    bcmp_pcoef u_pcoef (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_vld    (t_vld),
        .in_fine   (t_fine),
        .in_side   (t_side),
        .pcal_low  (pcal_low_reg),
        .pcal_high (pcal_high_reg),
        .out_vld   (c_vld),
        .out_item  (c_item)
    );

    bcmp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (c_vld),
        .in_item  (c_item),
        .out_vld  (d_vld),
        .out_item (d_item)
    );

    bcmp_pfin u_pfin (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_vld    (d_vld),
        .in_item   (d_item),
        .pcal_high (pcal_high_reg),
        .pcal_last (pcal_last_reg),
        .out_vld   (out_valid),
        .out_item  (out_data)
    );

    // checks
    `BCMP_ASSERT_NOW(a_invalid_zero, out_valid && out_data.pressure_invalid, out_data.pressure_q24_8 == 32'd0, "invalid pressure not forced to zero")
    `BCMP_ASSERT_NOW(a_take_when_empty, !out_valid, !in_stall, "input stalled with empty output")
    `BCMP_ASSERT_NXT(a_cfg_last, cfg_valid && cfg_index == CFG_IDX_LAST, pcal_last_reg == $past(cfg_data[15:0]), "last calibration write lost")

endmodule

`default_nettype wire
